/* rtl/core/echi_pkg.sv */
// ----------------------------------------------------------------------------
// Embedded-controller host interface package
// Shared types, command codes, status bits and sizing constants.
// ----------------------------------------------------------------------------
package echi_pkg;

    // Sizing of the controller space and the pending event queue.
    localparam int SPACE_BYTES = 256;
    localparam int EVENT_DEPTH = 8;
    localparam int SPACE_AW    = (SPACE_BYTES > 1) ? $clog2(SPACE_BYTES) : 1;
    localparam int EQ_AW       = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int EQ_CW       = $clog2(EVENT_DEPTH + 1);

    // Request operation codes.
    localparam logic [2:0] OP_HOST_CMD  = 3'd0;
    localparam logic [2:0] OP_HOST_DATA = 3'd1;
    localparam logic [2:0] OP_STATUS    = 3'd2;
    localparam logic [2:0] OP_DATA_READ = 3'd3;
    localparam logic [2:0] OP_POST      = 3'd4;
    localparam logic [2:0] OP_FW_WRITE  = 3'd5;

    // Host commands and the burst acknowledge byte.
    localparam logic [7:0] CMD_READ    = 8'h80;
    localparam logic [7:0] CMD_WRITE   = 8'h81;
    localparam logic [7:0] CMD_BE      = 8'h82;
    localparam logic [7:0] CMD_BD      = 8'h83;
    localparam logic [7:0] CMD_QUERY   = 8'h84;
    localparam logic [7:0] BURST_REPLY = 8'h90;

    // Status register bits.
    localparam logic [7:0] ST_OBF   = 8'h01;
    localparam logic [7:0] ST_IBF   = 8'h02;
    localparam logic [7:0] ST_CMD   = 8'h08;
    localparam logic [7:0] ST_BURST = 8'h10;
    localparam logic [7:0] ST_SCI   = 8'h20;

    // Fault codes.
    localparam logic [1:0] FLT_NONE    = 2'd0;
    localparam logic [1:0] FLT_UNKNOWN = 2'd1;
    localparam logic [1:0] FLT_STRAY   = 2'd2;
    localparam logic [1:0] FLT_QFULL   = 2'd3;

    // Host transaction phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_RD_OFF = 2'd1;
    localparam logic [1:0] PH_WR_OFF = 2'd2;
    localparam logic [1:0] PH_WR_VAL = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] port_byte;
        logic [7:0] local_addr;
    } req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] fault;
    } rsp_t;

    typedef struct packed {
        logic                we;
        logic [SPACE_AW-1:0] addr;
        logic [7:0]          data;
    } space_wr_t;

    typedef struct packed {
        logic             we;
        logic [EQ_AW-1:0] addr;
        logic [7:0]       data;
    } queue_wr_t;

    function automatic logic space_in_range(input logic [7:0] addr);
        return {1'b0, addr} < 9'(SPACE_BYTES);
    endfunction

endpackage

/* rtl/core/echi_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module echi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/echi_ctrl.sv */
// ----------------------------------------------------------------------------
// Embedded-controller host interface control
// Decodes requests, keeps the port state and drives both memories.
// ----------------------------------------------------------------------------
module echi_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  echi_pkg::req_t                req,
    output logic                          done,
    output echi_pkg::rsp_t                rsp,
    output logic [echi_pkg::SPACE_AW-1:0] space_raddr,
    input  logic [7:0]                    space_rdata,
    output echi_pkg::space_wr_t           space_wr,
    output logic [echi_pkg::EQ_AW-1:0]    queue_raddr,
    input  logic [7:0]                    queue_rdata,
    output echi_pkg::queue_wr_t           queue_wr
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                           state_reg, state_next;
    echi_pkg::req_t                 req_reg;
    logic                           hit_valid_reg;
    logic [1:0]                     phase_reg, phase_next;
    logic [7:0]                     offset_reg, offset_next;
    logic [7:0]                     out_byte_reg, out_byte_next;
    logic                           out_full_reg, out_full_next;
    logic                           last_cmd_reg, last_cmd_next;
    logic                           burst_reg, burst_next;
    logic [echi_pkg::EQ_AW-1:0]     head_reg, head_next;
    logic [echi_pkg::EQ_AW-1:0]     tail_reg, tail_next;
    logic [echi_pkg::EQ_CW-1:0]     count_reg, count_next;
    logic [echi_pkg::SPACE_BYTES-1:0] space_valid_reg;
    echi_pkg::rsp_t                 rsp_reg, rsp_next;
    logic                           done_reg;
    logic                           accept;
    logic [7:0]                     space_value;
    logic [echi_pkg::EQ_AW-1:0]     head_inc, tail_inc;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign rsp         = rsp_reg;
    assign space_raddr = req.port_byte[echi_pkg::SPACE_AW-1:0];
    assign queue_raddr = head_reg;

    // Entries never written since reset read as zero.
    assign space_value = (echi_pkg::space_in_range(req_reg.port_byte) && hit_valid_reg)
                         ? space_rdata : 8'h00;

    assign head_inc = (head_reg == echi_pkg::EQ_AW'(echi_pkg::EVENT_DEPTH - 1))
                      ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == echi_pkg::EQ_AW'(echi_pkg::EVENT_DEPTH - 1))
                      ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        state_next    = accept ? S_EXEC : S_IDLE;
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        out_byte_next = out_byte_reg;
        out_full_next = out_full_reg;
        last_cmd_next = last_cmd_reg;
        burst_next    = burst_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        rsp_next      = '{read_value: 8'h00, fault: echi_pkg::FLT_NONE};
        space_wr      = '{we: 1'b0, addr: req_reg.local_addr[echi_pkg::SPACE_AW-1:0],
                          data: req_reg.port_byte};
        queue_wr      = '{we: 1'b0, addr: tail_reg, data: req_reg.port_byte};

        if (state_reg == S_EXEC)
        begin
            case (req_reg.op)
                echi_pkg::OP_HOST_CMD:
                begin
                    last_cmd_next = 1'b1;
                    phase_next    = echi_pkg::PH_IDLE;
                    case (req_reg.port_byte)
                        echi_pkg::CMD_READ:  phase_next = echi_pkg::PH_RD_OFF;
                        echi_pkg::CMD_WRITE: phase_next = echi_pkg::PH_WR_OFF;
                        echi_pkg::CMD_BE:
                        begin
                            burst_next    = 1'b1;
                            out_byte_next = echi_pkg::BURST_REPLY;
                            out_full_next = 1'b1;
                        end
                        echi_pkg::CMD_BD:    burst_next = 1'b0;
                        echi_pkg::CMD_QUERY:
                        begin
                            out_full_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                out_byte_next = queue_rdata;
                                head_next     = head_inc;
                                count_next    = count_reg - 1'b1;
                            end
                            else
                            begin
                                out_byte_next = 8'h00;
                            end
                        end
                        default: rsp_next.fault = echi_pkg::FLT_UNKNOWN;
                    endcase
                end
                echi_pkg::OP_HOST_DATA:
                begin
                    last_cmd_next = 1'b0;
                    case (phase_reg)
                        echi_pkg::PH_RD_OFF:
                        begin
                            offset_next   = req_reg.port_byte;
                            out_byte_next = space_value;
                            out_full_next = 1'b1;
                            phase_next    = echi_pkg::PH_IDLE;
                        end
                        echi_pkg::PH_WR_OFF:
                        begin
                            offset_next = req_reg.port_byte;
                            phase_next  = echi_pkg::PH_WR_VAL;
                        end
                        echi_pkg::PH_WR_VAL:
                        begin
                            space_wr.we   = echi_pkg::space_in_range(offset_reg);
                            space_wr.addr = offset_reg[echi_pkg::SPACE_AW-1:0];
                            phase_next    = echi_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            phase_next     = echi_pkg::PH_IDLE;
                            rsp_next.fault = echi_pkg::FLT_STRAY;
                        end
                    endcase
                end
                echi_pkg::OP_STATUS:
                begin
                    rsp_next.read_value = (out_full_reg ? echi_pkg::ST_OBF : 8'h00)
                                        | (last_cmd_reg ? echi_pkg::ST_CMD : 8'h00)
                                        | (burst_reg ? echi_pkg::ST_BURST : 8'h00)
                                        | ((count_reg != '0) ? echi_pkg::ST_SCI : 8'h00);
                end
                echi_pkg::OP_DATA_READ:
                begin
                    rsp_next.read_value = out_byte_reg;
                    out_full_next       = 1'b0;
                end
                echi_pkg::OP_POST:
                begin
                    if (count_reg == echi_pkg::EQ_CW'(echi_pkg::EVENT_DEPTH))
                    begin
                        rsp_next.fault = echi_pkg::FLT_QFULL;
                    end
                    else
                    begin
                        queue_wr.we = 1'b1;
                        tail_next   = tail_inc;
                        count_next  = count_reg + 1'b1;
                    end
                end
                echi_pkg::OP_FW_WRITE:
                begin
                    space_wr.we = echi_pkg::space_in_range(req_reg.local_addr);
                end
                default:
                begin
                    rsp_next.read_value = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= echi_pkg::PH_IDLE;
            offset_reg      <= 8'h00;
            out_byte_reg    <= 8'h00;
            out_full_reg    <= 1'b0;
            last_cmd_reg    <= 1'b0;
            burst_reg       <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            space_valid_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            out_byte_reg <= out_byte_next;
            out_full_reg <= out_full_next;
            last_cmd_reg <= last_cmd_next;
            burst_reg    <= burst_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            done_reg     <= (state_reg == S_EXEC);
            if (space_wr.we)
            begin
                space_valid_reg[space_wr.addr] <= 1'b1;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req;
            hit_valid_reg <= space_valid_reg[req.port_byte[echi_pkg::SPACE_AW-1:0]];
        end
        if (state_reg == S_EXEC)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

/* rtl/core/embedded_controller_host_interface_core.sv */
// ----------------------------------------------------------------------------
// Embedded-controller host interface core
// Controller side of the host command/status and data ports, with a
// byte-addressed controller space and a queue of pending event codes.
//
// A request (req: op, port_byte, local_addr) is taken at a rising edge where
// start is high and busy is low. busy stays high for the one cycle in which
// the request executes. The controller space and the event queue each sit in
// a synchronous RAM; the reads are issued as the request is taken, and the
// execute cycle uses the read data and writes back.
// Every request produces exactly one result on rsp (read_value, fault),
// marked by a one-cycle done strobe registered from the execute state.
// A new request is not taken while the previous one executes (busy high).
// The receiver cannot stall: rsp is valid only while done is high.
// Reset clears all port state; controller space entries read as zero until
// they are written, tracked by a valid bit per entry, so no clearing pass is
// needed and requests are taken right after reset.
// ----------------------------------------------------------------------------
module embedded_controller_host_interface_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  echi_pkg::req_t req,
    output logic           done,
    output echi_pkg::rsp_t rsp
);

    logic [echi_pkg::SPACE_AW-1:0] space_raddr;
    logic [7:0]                    space_rdata;
    echi_pkg::space_wr_t           space_wr;
    logic [echi_pkg::EQ_AW-1:0]    queue_raddr;
    logic [7:0]                    queue_rdata;
    echi_pkg::queue_wr_t           queue_wr;

    echi_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .space_raddr (space_raddr),
        .space_rdata (space_rdata),
        .space_wr    (space_wr),
        .queue_raddr (queue_raddr),
        .queue_rdata (queue_rdata),
        .queue_wr    (queue_wr)
    );

    echi_ram #(
        .WIDTH (8),
        .DEPTH (echi_pkg::SPACE_BYTES)
    ) u_space_ram (
        .clk   (clk),
        .we    (space_wr.we),
        .waddr (space_wr.addr),
        .wdata (space_wr.data),
        .raddr (space_raddr),
        .rdata (space_rdata)
    );

    echi_ram #(
        .WIDTH (8),
        .DEPTH (echi_pkg::EVENT_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (queue_wr.we),
        .waddr (queue_wr.addr),
        .wdata (queue_wr.data),
        .raddr (queue_raddr),
        .rdata (queue_rdata)
    );

endmodule

/* dv/embedded_controller_host_interface_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedded-controller host interface core testbench
// Drives host port accesses and firmware actions through the start/busy
// handshake. A behavioral copy of the controller state computes the expected
// status, data and fault for every request, and each done strobe is checked
// against the oldest outstanding expectation. A short directed table comes
// first, then random host and firmware transactions under several sender idle rates.
// ----------------------------------------------------------------------------
module embedded_controller_host_interface_core_tb;

    import echi_pkg::*;

    typedef struct {
        req_t r;
        bit   pinned;
        rsp_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Directed rows may carry a hand-written expectation alongside the request.
    bit   row_pinned;
    rsp_t row_want;

    // Behavioral copy of the controller state.
    logic [7:0] ctl_space [SPACE_BYTES];
    logic [7:0] evq [EVENT_DEPTH];
    int         evq_head;
    int         evq_count;
    logic [1:0] host_phase;
    logic [7:0] offset_latch;
    logic [7:0] out_byte;
    logic       obf;
    logic       cmd_flag;
    logic       burst;

    rsp_t      expected_rsp [$];
    rsp_t      predicted;
    rsp_t      want;
    int        mismatches;
    int        idle_pct;
    int        sent_items;
    stim_row_t dir_rows [$];

    embedded_controller_host_interface_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        o = '0;
        case (r.op)
            OP_HOST_CMD:
            begin
                cmd_flag   = 1'b1;
                host_phase = PH_IDLE;
                case (r.port_byte)
                    CMD_READ:  host_phase = PH_RD_OFF;
                    CMD_WRITE: host_phase = PH_WR_OFF;
                    CMD_BE:
                    begin
                        burst    = 1'b1;
                        out_byte = BURST_REPLY;
                        obf      = 1'b1;
                    end
                    CMD_BD:    burst = 1'b0;
                    CMD_QUERY:
                    begin
                        if (evq_count != 0)
                        begin
                            out_byte  = evq[evq_head];
                            evq_head  = (evq_head + 1) % EVENT_DEPTH;
                            evq_count = evq_count - 1;
                        end
                        else
                        begin
                            out_byte = 8'h00;
                        end
                        obf = 1'b1;
                    end
                    default:   o.fault = FLT_UNKNOWN;
                endcase
            end
            OP_HOST_DATA:
            begin
                cmd_flag = 1'b0;
                case (host_phase)
                    PH_RD_OFF:
                    begin
                        offset_latch = r.port_byte;
                        out_byte = (int'(r.port_byte) < SPACE_BYTES) ?
                                   ctl_space[r.port_byte] : 8'h00;
                        obf        = 1'b1;
                        host_phase = PH_IDLE;
                    end
                    PH_WR_OFF:
                    begin
                        offset_latch = r.port_byte;
                        host_phase   = PH_WR_VAL;
                    end
                    PH_WR_VAL:
                    begin
                        if (int'(offset_latch) < SPACE_BYTES)
                            ctl_space[offset_latch] = r.port_byte;
                        host_phase = PH_IDLE;
                    end
                    default:
                    begin
                        host_phase = PH_IDLE;
                        o.fault    = FLT_STRAY;
                    end
                endcase
            end
            OP_STATUS:
            begin
                o.read_value = (obf ? ST_OBF : 8'h00) | (cmd_flag ? ST_CMD : 8'h00) |
                               (burst ? ST_BURST : 8'h00) |
                               ((evq_count != 0) ? ST_SCI : 8'h00);
            end
            OP_DATA_READ:
            begin
                o.read_value = out_byte;
                obf          = 1'b0;
            end
            OP_POST:
            begin
                if (evq_count >= EVENT_DEPTH)
                begin
                    o.fault = FLT_QFULL;
                end
                else
                begin
                    evq[(evq_head + evq_count) % EVENT_DEPTH] = r.port_byte;
                    evq_count = evq_count + 1;
                end
            end
            OP_FW_WRITE:
            begin
                if (int'(r.local_addr) < SPACE_BYTES)
                    ctl_space[r.local_addr] = r.port_byte;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Results come back in request order, so a plain FIFO of expectations works.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: read_value=%02h fault=%0d",
                                 rsp.read_value, rsp.fault);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_value !== want.read_value || rsp.fault !== want.fault)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected read_value=%02h fault=%0d, got %s",
                                     want.read_value, want.fault,
                                     $sformatf("read_value=%02h fault=%0d",
                                               rsp.read_value, rsp.fault));
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predicted = apply_request(req);
                expected_rsp.push_back(row_pinned ? row_want : predicted);
            end
        end
    end

    task automatic issue(input req_t r, input bit pin, input rsp_t pin_rsp);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        req        <= r;
        row_pinned <= pin;
        row_want   <= pin_rsp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send(input logic [2:0] op, input logic [7:0] pb, input logic [7:0] la);
        req_t r;
        r.op         = op;
        r.port_byte  = pb;
        r.local_addr = la;
        issue(r, 1'b0, '0);
        if (op <= OP_FW_WRITE)
            sent_items++;
    endtask

    // Stop requesting until every outstanding request has answered.
    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // Most offsets land in two small windows so that reads hit earlier writes.
    function automatic logic [7:0] pick_offset();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 8'($urandom_range(15));
        else if (sel < 85)
            return 8'(240 + $urandom_range(15));
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int n_items, input int pct);
        int kind;
        int n;
        idle_pct   = pct;
        sent_items = 0;
        while (sent_items < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 20)
            begin
                send(OP_HOST_CMD, CMD_READ, 8'($urandom_range(255)));
                send(OP_HOST_DATA, pick_offset(), 8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    send(OP_STATUS, 8'($urandom_range(255)), 8'($urandom_range(255)));
                if ($urandom_range(9) < 7)
                    send(OP_DATA_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (kind < 40)
            begin
                send(OP_HOST_CMD, CMD_WRITE, 8'($urandom_range(255)));
                send(OP_HOST_DATA, pick_offset(), 8'($urandom_range(255)));
                send(OP_HOST_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (kind < 50)
            begin
                send(OP_FW_WRITE, 8'($urandom_range(255)), pick_offset());
            end
            else if (kind < 58)
            begin
                // Long runs of posts fill the event queue.
                n = $urandom_range(1, 10);
                repeat (n)
                    send(OP_POST, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (kind < 70)
            begin
                send(OP_HOST_CMD, CMD_QUERY, 8'($urandom_range(255)));
                if ($urandom_range(1))
                    send(OP_STATUS, 8'($urandom_range(255)), 8'($urandom_range(255)));
                send(OP_DATA_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (kind < 76)
            begin
                send(OP_HOST_CMD, $urandom_range(1) ? CMD_BE : CMD_BD,
                     8'($urandom_range(255)));
                if ($urandom_range(1))
                    send(OP_DATA_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (kind < 82)
            begin
                send(OP_STATUS, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else
            begin
                // Noise: arbitrary ops, commands near the valid range, broken sequences.
                n = $urandom_range(1, 3);
                repeat (n)
                    send(3'($urandom_range(7)),
                         $urandom_range(1) ? 8'(CMD_READ + $urandom_range(7))
                                           : 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            end
            if ($urandom_range(99) == 0)
                drain_requests();
        end
        drain_requests();
    endtask

    function automatic stim_row_t stim_row(input logic [2:0] op, input logic [7:0] pb,
                                           input logic [7:0] la, input bit pin,
                                           input logic [7:0] rv, input logic [1:0] flt);
        stim_row_t d;
        d.r.op              = op;
        d.r.port_byte       = pb;
        d.r.local_addr      = la;
        d.pinned            = pin;
        d.want.read_value   = rv;
        d.want.fault        = flt;
        return d;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        row_pinned   = 1'b0;
        row_want     = '0;
        mismatches   = 0;
        idle_pct     = 0;
        sent_items   = 0;
        foreach (ctl_space[i])
            ctl_space[i] = 8'h00;
        foreach (evq[i])
            evq[i] = 8'h00;
        evq_head     = 0;
        evq_count    = 0;
        host_phase   = PH_IDLE;
        offset_latch = 8'h00;
        out_byte     = 8'h00;
        obf          = 1'b0;
        cmd_flag     = 1'b0;
        burst        = 1'b0;

        dir_rows.push_back(stim_row(OP_STATUS,    8'h00, 8'h00, 1, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_DATA_READ, 8'hFF, 8'hFF, 1, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_DATA, 8'hFF, 8'h00, 1, 8'h00, FLT_STRAY));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  8'h00, 8'h00, 1, 8'h00, FLT_UNKNOWN));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  8'hFF, 8'hFF, 1, 8'h00, FLT_UNKNOWN));
        dir_rows.push_back(stim_row(OP_FW_WRITE,  8'hA5, 8'hFF, 1, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_READ, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_DATA, 8'hFF, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_DATA_READ, 8'h00, 8'h00, 1, 8'hA5, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_WRITE, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_DATA, 8'h00, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_DATA, 8'hFF, 8'h00, 0, 8'h00, FLT_NONE));
        // A new command drops the pending write.
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_WRITE, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_READ, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_DATA, 8'h00, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_STATUS,    8'h00, 8'h00, 1, ST_OBF, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_BE, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_DATA_READ, 8'h00, 8'h00, 1, BURST_REPLY, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_BD, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_QUERY, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(3'd6,         8'hFF, 8'hFF, 1, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(3'd7,         8'hFF, 8'hFF, 1, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_POST,      8'hFF, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_HOST_CMD,  CMD_QUERY, 8'h00, 0, 8'h00, FLT_NONE));
        dir_rows.push_back(stim_row(OP_DATA_READ, 8'h00, 8'h00, 1, 8'hFF, FLT_NONE));

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].r, dir_rows[i].pinned, dir_rows[i].want);
        drain_requests();

        run_phase(500, 0);
        run_phase(500, 56);
        run_phase(500, 0);
        run_phase(500, 7);

        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
